// ===== rtl/core/mbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
package mbe_pkg;

  // parameter defaults
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 28;
  localparam int ITER_BITS_DEF  = 10;

  // fixed field widths
  localparam int FIX_W       = 32;   // Q4.28 word
  localparam int PROD_W      = 64;   // full product
  localparam int STEP_W      = 31;
  localparam int PITCH_W     = 13;
  localparam int INDEX_W     = 24;
  localparam int COLOR_W     = 24;
  localparam int SCALE_BITS  = 8;    // count*255 = (count << 8) - count
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFF_FFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_REAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_IMAG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH  = 3'd5;

  // register reset values
  localparam logic signed [FIX_W-1:0] ORIGIN_REAL_RST = -32'sd563714458;
  localparam logic signed [FIX_W-1:0] ORIGIN_IMAG_RST = -32'sd322122547;
  localparam logic [STEP_W-1:0]       STEP_REAL_RST   = 31'd905970;
  localparam logic [STEP_W-1:0]       STEP_IMAG_RST   = 31'd1073742;
  localparam int                      ITER_LIMIT_RST  = 40;
  localparam logic [PITCH_W-1:0]      LINE_PITCH_RST  = 13'd800;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_ADD,
    S_ITER_MUL,
    S_ITER_UPD,
    S_DIV_START,
    S_DIV_RUN,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic map_mul;
    logic map_add;
    logic it_mul;
    logic it_upd;
    logic div_start;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more;      // count below limit
    logic escape;    // |z|^2 >= 4
    logic div_busy;
  } sts_t;

endpackage

// ===== rtl/core/mbe_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mbe_div #(
  parameter int DVD_W = 18,
  parameter int DVS_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);
  import mbe_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_nxt  = {quo_r[DVD_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

`ifndef ASSERT_OFF
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("divider busy with zero step count");
`endif

endmodule

// ===== rtl/core/mbe_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_dp
// Datapath: coordinate mapping, z iteration, colour divide, result register.
// ----------------------------------------------------------------------------
module mbe_dp #(
  parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS  = mbe_pkg::ITER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mbe_pkg::cmd_t                     cmd,
  output mbe_pkg::sts_t                     sts,
  input  logic [COORD_BITS-1:0]             pixel_x,
  input  logic [COORD_BITS-1:0]             pixel_y,
  input  logic signed [mbe_pkg::FIX_W-1:0]  origin_real,
  input  logic signed [mbe_pkg::FIX_W-1:0]  origin_imag,
  input  logic [mbe_pkg::STEP_W-1:0]        step_real,
  input  logic [mbe_pkg::STEP_W-1:0]        step_imag,
  input  logic [ITER_BITS-1:0]              iteration_limit,
  input  logic [mbe_pkg::PITCH_W-1:0]       line_pitch,
  output logic [mbe_pkg::INDEX_W-1:0]       pixel_index,
  output logic [ITER_BITS-1:0]              iteration_count,
  output logic [mbe_pkg::COLOR_W-1:0]       pixel_color
);
  import mbe_pkg::*;

  localparam int MAPP_W = COORD_BITS + STEP_W;
  localparam int IDXP_W = COORD_BITS + PITCH_W;
  localparam int DVD_W  = ITER_BITS + SCALE_BITS;
  localparam logic signed [PROD_W-1:0] FOUR = 64'sd1 <<< (FRAC_BITS + 2);

  logic [COORD_BITS-1:0]     x_r, y_r;
  logic [MAPP_W-1:0]         px_r, py_r;
  logic [IDXP_W-1:0]         pidx_r;
  logic signed [FIX_W-1:0]   cre_r, cim_r;
  logic [INDEX_W-1:0]        index_r;
  logic signed [FIX_W-1:0]   zr_r, zi_r;
  logic signed [PROD_W-1:0]  prr_r, pii_r, pri_r;
  logic [ITER_BITS-1:0]      count_r;
  logic [INDEX_W-1:0]        out_index_r;
  logic [ITER_BITS-1:0]      out_count_r;
  logic [COLOR_W-1:0]        out_color_r;

  logic signed [PROD_W-1:0]  sq_re, sq_im, mag, twice_ri;
  logic [DVD_W-1:0]          dividend;
  logic [DVD_W-1:0]          quotient;
  logic                      div_busy;
  logic [COLOR_W-1:0]        color;

  // floor shifts of the products
  assign sq_re    = prr_r >>> FRAC_BITS;
  assign sq_im    = pii_r >>> FRAC_BITS;
  assign twice_ri = pri_r >>> (FRAC_BITS - 1);
  assign mag      = sq_re + sq_im;

  assign dividend = DVD_W'({count_r, {SCALE_BITS{1'b0}}}) - DVD_W'(count_r);
  assign color    = (count_r == iteration_limit) ? COLOR_WHITE : COLOR_W'(quotient);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r <= pixel_x;
      y_r <= pixel_y;
    end
    if (cmd.map_mul) begin
      px_r   <= MAPP_W'(x_r) * MAPP_W'(step_real);
      py_r   <= MAPP_W'(y_r) * MAPP_W'(step_imag);
      pidx_r <= IDXP_W'(y_r) * IDXP_W'(line_pitch);
    end
    if (cmd.map_add) begin
      cre_r   <= origin_real + signed'(px_r[FIX_W-1:0]);
      cim_r   <= origin_imag + signed'(py_r[FIX_W-1:0]);
      index_r <= INDEX_W'(x_r) + INDEX_W'(pidx_r);
      zr_r    <= '0;
      zi_r    <= '0;
      count_r <= '0;
    end
    if (cmd.it_mul) begin
      prr_r <= PROD_W'(zr_r) * PROD_W'(zr_r);
      pii_r <= PROD_W'(zi_r) * PROD_W'(zi_r);
      pri_r <= PROD_W'(zr_r) * PROD_W'(zi_r);
    end
    if (cmd.it_upd) begin
      zr_r    <= sq_re[FIX_W-1:0] - sq_im[FIX_W-1:0] + cre_r;
      zi_r    <= twice_ri[FIX_W-1:0] + cim_r;
      count_r <= count_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_index_r <= index_r;
      out_count_r <= count_r;
      out_color_r <= color;
    end
  end

  mbe_div #(
    .DVD_W (DVD_W),
    .DVS_W (ITER_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (iteration_limit),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign sts.more     = count_r < iteration_limit;
  assign sts.escape   = mag >= FOUR;
  assign sts.div_busy = div_busy;

  assign pixel_index     = out_index_r;
  assign iteration_count = out_count_r;
  assign pixel_color     = out_color_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.it_upd |-> (count_r < iteration_limit))
    else $error("iteration past the limit");
`endif

endmodule

// ===== rtl/core/mbe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer for one pixel: map, iterate, divide if it escapes, hand over the result word.
// ----------------------------------------------------------------------------
module mbe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  mbe_pkg::sts_t sts,
  output mbe_pkg::cmd_t cmd
);
  import mbe_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_MAP_MUL;
      S_MAP_MUL:   state_nxt = S_MAP_ADD;
      S_MAP_ADD:   state_nxt = S_ITER_MUL;
      S_ITER_MUL:  state_nxt = sts.more ? S_ITER_UPD : S_DONE;
      S_ITER_UPD:  state_nxt = sts.escape ? S_DIV_START : S_ITER_MUL;
      S_DIV_START: state_nxt = S_DIV_RUN;
      S_DIV_RUN:   if (!sts.div_busy) state_nxt = S_DONE;
      S_DONE:      if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      S_MAP_MUL:   cmd.map_mul   = 1'b1;
      S_MAP_ADD:   cmd.map_add   = 1'b1;
      S_ITER_MUL:  cmd.it_mul    = sts.more;
      S_ITER_UPD:  cmd.it_upd    = !sts.escape;
      S_DIV_START: cmd.div_start = 1'b1;
      S_DIV_RUN:   cmd           = '0;
      S_DONE:      cmd.load_out  = out_free;
      default:     cmd           = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result word overwritten while held");

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result valid without finishing a pixel");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MAP_MUL))
    else $error("accepted word did not start mapping");
`endif

endmodule

// ===== rtl/core/mandelbrot_escape_time_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time evaluator for one pixel: maps (x, y) to c, iterates z = z^2 + c
// in Q4.28 and returns frame-buffer index, iteration count and colour.
// ----------------------------------------------------------------------------
//
// channel  direction  handshake            word
// in_      sink       in_valid / in_stall    pixel_x, pixel_y
// out_     source     out_valid / out_stall  pixel_index, iteration_count,
//                                            pixel_color
// cfg_     sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The mapping is a multiply state, then an add state; each iteration is a
// multiply state, then a shift/test/update state. A pixel that escapes runs
// the bit-serial colour divide (start, then run) before its result is
// loaded; a pixel that reaches the limit is loaded without it. The sequencer
// returns to idle after each result, and the next word is taken there.
// One pixel in flight; the next word is taken once the result sits in the
// output register, even if out_stall holds it there.
// Reset (synchronous, rst_n low) returns the sequencer to idle, drops
// out_valid and loads the register defaults. cfg_ready is always high.
//
module mandelbrot_escape_time_pixel #(
  parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = mbe_pkg::FRAC_BITS_DEF,
  parameter int ITER_BITS  = mbe_pkg::ITER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel in
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [COORD_BITS-1:0]              in_pixel_x,
  input  logic [COORD_BITS-1:0]              in_pixel_y,
  // result out
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mbe_pkg::INDEX_W-1:0]        out_pixel_index,
  output logic [ITER_BITS-1:0]               out_iteration_count,
  output logic [mbe_pkg::COLOR_W-1:0]        out_pixel_color,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mbe_pkg::*;

  // register file
  logic signed [FIX_W-1:0] origin_real_r;
  logic signed [FIX_W-1:0] origin_imag_r;
  logic [STEP_W-1:0]       step_real_r;
  logic [STEP_W-1:0]       step_imag_r;
  logic [ITER_BITS-1:0]    iter_limit_r;
  logic [PITCH_W-1:0]      line_pitch_r;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // writes land at once; out-of-range indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_real_r <= ORIGIN_REAL_RST;
      origin_imag_r <= ORIGIN_IMAG_RST;
      step_real_r   <= STEP_REAL_RST;
      step_imag_r   <= STEP_IMAG_RST;
      iter_limit_r  <= ITER_BITS'(ITER_LIMIT_RST);
      line_pitch_r  <= LINE_PITCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_REAL: origin_real_r <= signed'(cfg_data[FIX_W-1:0]);
        CFG_ORIGIN_IMAG: origin_imag_r <= signed'(cfg_data[FIX_W-1:0]);
        CFG_STEP_REAL:   step_real_r   <= cfg_data[STEP_W-1:0];
        CFG_STEP_IMAG:   step_imag_r   <= cfg_data[STEP_W-1:0];
        CFG_ITER_LIMIT:  iter_limit_r  <= cfg_data[ITER_BITS-1:0];
        CFG_LINE_PITCH:  line_pitch_r  <= cfg_data[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbe_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .pixel_x         (in_pixel_x),
    .pixel_y         (in_pixel_y),
    .origin_real     (origin_real_r),
    .origin_imag     (origin_imag_r),
    .step_real       (step_real_r),
    .step_imag       (step_imag_r),
    .iteration_limit (iter_limit_r),
    .line_pitch      (line_pitch_r),
    .pixel_index     (out_pixel_index),
    .iteration_count (out_iteration_count),
    .pixel_color     (out_pixel_color)
  );

endmodule

// ===== verif/mandelbrot_escape_time_pixel_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_tb
// Self-checking bench for the escape-time pixel evaluator. A short table of
// probes walks the register extremes, the zero and unit iteration limits and
// index wrap. Random views of the set follow, plus some register noise. Every
// result word is checked field by field against its table entry or an
// in-bench fixed-point model, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_tb;
  import mbe_pkg::*;

  localparam int COORD_W = COORD_BITS_DEF;
  localparam int FRAC_W  = FRAC_BITS_DEF;
  localparam int ITER_W  = ITER_BITS_DEF;

  localparam int          RANDOM_PIXELS = 1130;
  localparam int          QUIET_TAIL    = 100;   // last words run with no idling
  localparam int          DRAIN_CYCLES  = 64;
  localparam int          REPORT_MAX    = 200;
  localparam int unsigned CYCLE_LIMIT   = 10_000_000;
  localparam int          COLOR_SCALE   = 255;
  localparam int          LIMIT_MAX     = (1 << ITER_W) - 1;

  // |z|^2 bound of 4.0 in Q4.28, held at product width
  localparam logic signed [PROD_W-1:0] ESCAPE_R2 = 64'sd4 <<< FRAC_W;

  // indexes with no register behind them; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [ITER_W-1:0]  count;
    logic [COLOR_W-1:0] color;
  } pixel_word_t;

  // raw register write data; upper bits beyond each width are deliberately dirty
  typedef struct packed {
    logic [CFG_DATA_W-1:0] org_re, org_im, step_re, step_im, limit, pitch;
  } view_t;

  typedef struct {
    int           view_id;   // 0: registers as left by reset
    logic [COORD_W-1:0] px, py;
    bit           typed;     // expected word given in the table
    pixel_word_t  want;
  } probe_t;

  typedef enum {VIEW_FRAMED, VIEW_NOISE, VIEW_DEEP} view_kind_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [COORD_W-1:0] in_pixel_x = '0;
  logic [COORD_W-1:0] in_pixel_y = '0;

  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [INDEX_W-1:0] out_pixel_index;
  logic [ITER_W-1:0]  out_iteration_count;
  logic [COLOR_W-1:0] out_pixel_color;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // shadow of the block's registers, updated on each accepted write
  logic signed [FIX_W-1:0] cur_org_re, cur_org_im;
  logic [STEP_W-1:0]       cur_step_re, cur_step_im;
  logic [ITER_W-1:0]       cur_limit;
  logic [PITCH_W-1:0]      cur_pitch;

  pixel_word_t pending_px [$];   // words owed by the block, oldest first
  int          errors     = 0;
  logic        idle_on    = 1'b0;
  int          stall_left = 0;

  mandelbrot_escape_time_pixel dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pixel_index     (out_pixel_index),
    .out_iteration_count (out_iteration_count),
    .out_pixel_color     (out_pixel_color),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Escape-time evaluation in Q4.28. c wraps to 32 bits, squares are exact
  // 64-bit products floored by the arithmetic shift, z wraps each update.
  function automatic pixel_word_t escape_pixel(input logic [COORD_W-1:0] px, py);
    logic [FIX_W+COORD_W-1:0] span_re, span_im;
    logic [FIX_W-1:0]         c_lo;
    logic signed [PROD_W-1:0] c_re, c_im, zr, zi, sq_re, sq_im, twice_ri, nxt;
    int                       n;
    pixel_word_t              w;
    span_re = px * cur_step_re;
    span_im = py * cur_step_im;
    c_lo = cur_org_re + span_re[FIX_W-1:0];
    c_re = $signed(c_lo);
    c_lo = cur_org_im + span_im[FIX_W-1:0];
    c_im = $signed(c_lo);
    zr = '0;
    zi = '0;
    n  = 0;
    while (n < int'(cur_limit)) begin
      sq_re = (zr * zr) >>> FRAC_W;
      sq_im = (zi * zi) >>> FRAC_W;
      if (sq_re + sq_im >= ESCAPE_R2) break;
      twice_ri = (zr * zi) >>> (FRAC_W - 1);   // 2*zr*zi
      nxt = sq_re - sq_im + c_re;
      zr  = $signed(nxt[FIX_W-1:0]);
      nxt = twice_ri + c_im;
      zi  = $signed(nxt[FIX_W-1:0]);
      n++;
    end
    w.index = INDEX_W'(int'(px) + int'(py) * int'(cur_pitch));
    w.count = ITER_W'(n);
    // a zero limit lands here too, so no divide by zero
    if (n == int'(cur_limit)) begin
      w.color = COLOR_WHITE;
    end else begin
      w.color = COLOR_W'((n * COLOR_SCALE) / int'(cur_limit));
    end
    return w;
  endfunction

  function automatic probe_t mk_probe(input int view_id, input int px, py,
                                      input bit typed = 1'b0, input int idx = 0,
                                      input int cnt = 0,
                                      input logic [COLOR_W-1:0] col = '0);
    probe_t p;
    p.view_id    = view_id;
    p.px         = COORD_W'(px);
    p.py         = COORD_W'(py);
    p.typed      = typed;
    p.want.index = INDEX_W'(idx);
    p.want.count = ITER_W'(cnt);
    p.want.color = col;
    return p;
  endfunction

  // Only called with nothing in flight. Valid stays up across back-to-back
  // writes and drops after the last one.
  task automatic load_view(input view_t v, input bit poke_spare);
    logic [CFG_IDX_W-1:0]  reg_idx [7];
    logic [CFG_DATA_W-1:0] reg_val [7];
    int                    n_writes;
    reg_idx = '{CFG_ORIGIN_REAL, CFG_ORIGIN_IMAG, CFG_STEP_REAL, CFG_STEP_IMAG,
                CFG_ITER_LIMIT, CFG_LINE_PITCH,
                ($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO};
    reg_val = '{v.org_re, v.org_im, v.step_re, v.step_im, v.limit, v.pitch,
                $urandom};
    n_writes = poke_spare ? 7 : 6;
    for (int i = 0; i < n_writes; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_data  <= reg_val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (reg_idx[i])
        CFG_ORIGIN_REAL: cur_org_re  = reg_val[i];
        CFG_ORIGIN_IMAG: cur_org_im  = reg_val[i];
        CFG_STEP_REAL:   cur_step_re = reg_val[i][STEP_W-1:0];
        CFG_STEP_IMAG:   cur_step_im = reg_val[i][STEP_W-1:0];
        CFG_ITER_LIMIT:  cur_limit   = reg_val[i][ITER_W-1:0];
        CFG_LINE_PITCH:  cur_pitch   = reg_val[i][PITCH_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Offers one pixel word, optionally after an idle burst; the expected word
  // is queued at the edge that takes it.
  task automatic send_pixel(input logic [COORD_W-1:0] px, py, input bit typed,
                            input pixel_word_t want, input bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_px.push_back(typed ? want : escape_pixel(px, py));
  endtask

  // Hold the sender until every owed word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_px.size() != 0);
  endtask

  task automatic check_field(input string what, input longint unsigned want, got);
    if (want != got) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  // Result-side stall: random bursts while idling is on, never back to back.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_stall  <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    pixel_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t ns: word with none expected, expected nothing got %0d/%0d/%06h",
                   $time, out_pixel_index, out_iteration_count, out_pixel_color);
      end else begin
        want = pending_px.pop_front();
        check_field("pixel_index", want.index, out_pixel_index);
        check_field("iteration_count", want.count, out_iteration_count);
        check_field("pixel_color", want.color, out_pixel_color);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[mandelbrot_escape_time_pixel] ERROR");
    $finish;
  end

  initial begin : stimulus
    view_t      views [1:4];
    probe_t     probes [$];
    view_t      v;
    view_kind_t kind;
    int         cur_view, sent, n_items, hold_at;
    bit         phase_idle, calm;

    cur_org_re  = ORIGIN_REAL_RST;
    cur_org_im  = ORIGIN_IMAG_RST;
    cur_step_re = STEP_REAL_RST;
    cur_step_im = STEP_IMAG_RST;
    cur_limit   = ITER_W'(ITER_LIMIT_RST);
    cur_pitch   = LINE_PITCH_RST;

    // 1: zero limit via a write whose low ten bits are clear; origins at the
    //    extremes, step data with the dropped top bit set
    views[1] = '{org_re: 32'h8000_0000, org_im: 32'h7FFF_FFFF,
                 step_re: 32'hFFFF_FFFF, step_im: 32'h8000_0000,
                 limit: 32'hFFFF_FC00, pitch: 32'h8000_0320};
    // 2: unit limit, widest pitch so x + y*pitch wraps past 24 bits
    views[2] = '{org_re: 32'h0000_0000, org_im: 32'h0000_0000,
                 step_re: 32'h7FFF_FFFF, step_im: 32'h7FFF_FFFF,
                 limit: 32'h0000_0001, pitch: 32'h0000_1FFF};
    // 3: c pinned far outside, escapes on the second pass; top limit
    views[3] = '{org_re: 32'h7FFF_FFFF, org_im: 32'h8000_0000,
                 step_re: 32'h0000_0000, step_im: 32'h0000_0000,
                 limit: 32'h0000_03FF, pitch: 32'h0000_1000};
    // 4: c sat on the -0.75 pinch point, runs to the top limit; pitch zero
    views[4] = '{org_re: 32'hF400_0000, org_im: 32'h0000_0000,
                 step_re: 32'h0000_0001, step_im: 32'h0000_0010,
                 limit: 32'h0000_03FF, pitch: 32'hFFFF_E000};

    // reset registers: corners, the bulb centre region and a near-origin point
    probes.push_back(mk_probe(0, 0, 0));
    probes.push_back(mk_probe(0, 4095, 4095));
    probes.push_back(mk_probe(0, 4095, 0));
    probes.push_back(mk_probe(0, 0, 4095));
    probes.push_back(mk_probe(0, 474, 300));
    probes.push_back(mk_probe(0, 2048, 2048));
    probes.push_back(mk_probe(0, 1, 1));
    probes.push_back(mk_probe(1, 0, 0, 1'b1, 0, 0, COLOR_WHITE));
    probes.push_back(mk_probe(1, 4095, 4095, 1'b1, 3280095, 0, COLOR_WHITE));
    probes.push_back(mk_probe(1, 4095, 0, 1'b1, 4095, 0, COLOR_WHITE));
    probes.push_back(mk_probe(1, 0, 4095, 1'b1, 3276000, 0, COLOR_WHITE));
    probes.push_back(mk_probe(2, 4095, 4095, 1'b1, 16769024, 1, COLOR_WHITE));
    probes.push_back(mk_probe(2, 0, 4095, 1'b1, 16764929, 1, COLOR_WHITE));
    probes.push_back(mk_probe(2, 2048, 2048, 1'b1, 0, 1, COLOR_WHITE));
    probes.push_back(mk_probe(2, 4095, 0, 1'b1, 4095, 1, COLOR_WHITE));
    probes.push_back(mk_probe(3, 4095, 4095, 1'b1, 16777215, 1, 0));
    probes.push_back(mk_probe(3, 0, 0, 1'b1, 0, 1, 0));
    probes.push_back(mk_probe(3, 100, 1, 1'b1, 4196, 1, 0));
    probes.push_back(mk_probe(4, 0, 0));
    probes.push_back(mk_probe(4, 4095, 4095));
    probes.push_back(mk_probe(4, 7, 4000));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    cur_view = 0;
    foreach (probes[i]) begin
      if (probes[i].view_id != cur_view) begin
        settle();
        load_view(views[probes[i].view_id], 1'b0);
        cur_view = probes[i].view_id;
      end
      phase_idle = ($urandom_range(0, 1) != 0);
      idle_on <= phase_idle;
      send_pixel(probes[i].px, probes[i].py, probes[i].typed, probes[i].want,
                 phase_idle);
    end
    settle();

    // Random views. Framed ones cover a window over the set so many points
    // run long; noise views load arbitrary data; deep ones use the top limit
    // with few words since each can run long.
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: kind = VIEW_FRAMED;
        6, 7, 8:          kind = VIEW_NOISE;
        default:          kind = VIEW_DEEP;
      endcase
      v.org_re  = $urandom;
      v.org_im  = $urandom;
      v.step_re = $urandom;
      v.step_im = $urandom;
      v.limit   = $urandom;
      v.pitch   = $urandom;
      if (kind != VIEW_NOISE) begin
        v.org_re  = -$urandom_range(32'h0800_0000, 32'h2800_0000);
        v.org_im  = -$urandom_range(0, 32'h1800_0000);
        v.step_re = ($urandom & 32'h8000_0000) | $urandom_range(32'h400, 32'h4_0000);
        v.step_im = ($urandom & 32'h8000_0000) | $urandom_range(32'h400, 32'h4_0000);
        v.limit   = ($urandom & 32'hFFFF_FC00) |
                    ((kind == VIEW_DEEP) ? LIMIT_MAX : $urandom_range(1, 96));
        v.pitch   = ($urandom & 32'hFFFF_E000) | $urandom_range(1, 4096);
      end
      load_view(v, $urandom_range(0, 1) != 0);

      n_items = (v.limit[ITER_W-1:0] > 200) ? 16 : $urandom_range(60, 140);
      if (n_items > RANDOM_PIXELS - sent) n_items = RANDOM_PIXELS - sent;
      phase_idle = ($urandom_range(0, 3) != 0);
      hold_at    = $urandom_range(0, n_items - 1);
      for (int i = 0; i < n_items; i++) begin
        calm = (sent >= RANDOM_PIXELS - QUIET_TAIL);
        // sender waits for a full drain at most once per view, mid-stream
        if (i == hold_at && i != 0 && !calm) settle();
        idle_on <= phase_idle && !calm;
        send_pixel(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)),
                   1'b0, '0, phase_idle && !calm);
        sent++;
      end
      settle();
    end

    // catch any stray word after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[mandelbrot_escape_time_pixel] OK");
    end else begin
      $display("[mandelbrot_escape_time_pixel] ERROR");
    end
    $finish;
  end

endmodule
